### rtl/sbm_pkg.sv
// Shared types and constants of the SCCB bus master.
package sbm_pkg;

  localparam int unsigned CFG_W = 16;
  localparam int unsigned BYTE_W = 8;

  // Register indexes on the configuration port
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_SETUP = 1'b1;

  localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [CFG_W-1:0] ACK_SETUP_RST = 16'd1;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_NACK  = 3'd4
  } op_e;

  // One tick as classified by the front end
  typedef struct packed {
    logic              start;
    op_e               op;
    logic [BYTE_W-1:0] tx;
    logic              sda;
  } item_t;

  // Bus and status view after one tick
  typedef struct packed {
    logic              scl;
    logic              sda;
    logic              oe;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rx;
    logic              ack;
  } res_t;

endpackage

### rtl/sbm_fifo.sv
// Small register-based first-in first-out queue.
module sbm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr, rd;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/sbm_front.sv
// Front end: classify each incoming tick and queue it for the sequencer.
module sbm_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic               cmd_valid_i,
  input  logic [2:0]         op_i,
  input  logic [7:0]         tx_byte_i,
  input  logic               sda_in_i,
  output logic               item_valid_o,
  output sbm_pkg::item_t     item_o,
  input  logic               item_pop_i
);
  import sbm_pkg::*;

  item_t item_in;
  logic  legal;
  logic  empty;

  // Only known opcodes may launch a sequence
  assign legal = cmd_valid_i && (op_i <= OP_NACK);

  always_comb begin
    item_in.start = legal;
    item_in.op    = legal ? op_e'(op_i) : OP_START;
    item_in.tx    = tx_byte_i;
    item_in.sda   = sda_in_i;
  end

  sbm_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (item_in),
    .full_o (full_o),
    .pop_i  (item_pop_i),
    .data_o (item_o),
    .empty_o(empty)
  );

  assign item_valid_o = !empty;

endmodule

### rtl/sbm_seq.sv
// Back end: bus phase sequencer, at most one bus action per clock cycle while not stalled.
module sbm_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [sbm_pkg::CFG_W-1:0]  half_period_i,
  input  logic [sbm_pkg::CFG_W-1:0]  ack_setup_i,
  input  logic                       item_valid_i,
  input  sbm_pkg::item_t             item_i,
  output logic                       item_pop_o,
  input  logic                       res_full_i,
  output logic                       res_push_o,
  output sbm_pkg::res_t              res_o
);
  import sbm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_STEP1 = 4'd1,
    PH_STEP2 = 4'd2,
    PH_STEP3 = 4'd3,
    PH_STEP4 = 4'd4,
    PH_STEP5 = 4'd5,
    PH_STEP6 = 4'd6,
    PH_STEP7 = 4'd7
  } phase_e;

  typedef struct packed {
    op_e               cmd;
    phase_e            phase;
    logic [3:0]        bit_cnt;
    logic [BYTE_W-1:0] shift;
    logic [CFG_W-1:0]  wait_cnt;
    logic              scl;
    logic              sda;
    logic              oe;
    logic [BYTE_W-1:0] rx;
    logic              ack;
  } seq_t;

  seq_t st_q, st_d;
  seq_t pre, post;
  logic mid_q, mid_d;
  logic done_acc_q, done_acc_d;
  logic run, act, fin, cont, step;
  logic [3:0] bit_nxt;

  always_comb begin
    pre     = st_q;
    run     = 1'b0;
    bit_nxt = st_q.bit_cnt + 1'b1;
    // Tick entry: latch a new command or count down the current hold; mid-tick, run the next action
    if (!mid_q) begin
      if (st_q.phase == PH_IDLE) begin
        if (item_i.start) begin
          pre.cmd      = item_i.op;
          pre.phase    = PH_STEP1;
          pre.bit_cnt  = '0;
          pre.shift    = (item_i.op == OP_WRITE) ? item_i.tx : '0;
          pre.wait_cnt = '0;
          run          = 1'b1;
        end
      end else begin
        if (st_q.wait_cnt != '0) begin
          pre.wait_cnt = st_q.wait_cnt - 1'b1;
        end
        run = (pre.wait_cnt == '0);
      end
    end else begin
      run = 1'b1;
    end

    act  = run && (pre.phase != PH_IDLE) && (pre.wait_cnt == '0);
    post = pre;
    fin  = 1'b0;
    if (act) begin
      post.wait_cnt = half_period_i;
      case (pre.cmd)
        OP_START: begin
          case (pre.phase)
            PH_STEP1: begin post.oe = 1'b1; post.sda = 1'b1; post.phase = PH_STEP2; end
            PH_STEP2: begin post.scl = 1'b1; post.phase = PH_STEP3; end
            PH_STEP3: begin post.sda = 1'b0; post.phase = PH_STEP4; end
            PH_STEP4: begin post.scl = 1'b0; post.phase = PH_STEP5; end
            default:  fin = 1'b1;
          endcase
        end
        OP_STOP: begin
          case (pre.phase)
            PH_STEP1: begin post.oe = 1'b1; post.sda = 1'b0; post.phase = PH_STEP2; end
            PH_STEP2: begin post.scl = 1'b1; post.phase = PH_STEP3; end
            PH_STEP3: begin post.sda = 1'b1; post.phase = PH_STEP4; end
            default:  fin = 1'b1;
          endcase
        end
        OP_WRITE: begin
          case (pre.phase)
            PH_STEP1: begin
              post.oe    = 1'b1;
              post.sda   = pre.shift[BYTE_W-1];
              post.shift = {pre.shift[BYTE_W-2:0], 1'b0};
              post.scl   = 1'b1;
              post.phase = PH_STEP2;
            end
            PH_STEP2: begin
              post.scl     = 1'b0;
              post.bit_cnt = bit_nxt;
              post.phase   = (bit_nxt < BITS_PER_BYTE) ? PH_STEP1 : PH_STEP3;
            end
            PH_STEP3: begin post.wait_cnt = ack_setup_i; post.phase = PH_STEP4; end
            PH_STEP4: begin post.oe = 1'b0; post.phase = PH_STEP5; end
            PH_STEP5: begin post.scl = 1'b1; post.phase = PH_STEP6; end
            PH_STEP6: begin
              post.ack   = item_i.sda;
              post.scl   = 1'b0;
              post.phase = PH_STEP7;
            end
            default: begin post.oe = 1'b1; fin = 1'b1; end
          endcase
        end
        OP_READ: begin
          case (pre.phase)
            PH_STEP1: begin post.oe = 1'b0; post.phase = PH_STEP2; end
            PH_STEP2: post.phase = PH_STEP3;
            PH_STEP3: begin post.scl = 1'b1; post.phase = PH_STEP4; end
            PH_STEP4: begin
              post.shift   = {pre.shift[BYTE_W-2:0], item_i.sda};
              post.scl     = 1'b0;
              post.bit_cnt = bit_nxt;
              post.phase   = (bit_nxt < BITS_PER_BYTE) ? PH_STEP2 : PH_STEP5;
            end
            default: begin post.rx = pre.shift; fin = 1'b1; end
          endcase
        end
        default: begin
          case (pre.phase)
            PH_STEP1: begin post.oe = 1'b1; post.sda = 1'b1; post.phase = PH_STEP2; end
            PH_STEP2: begin post.scl = 1'b1; post.phase = PH_STEP3; end
            PH_STEP3: begin post.scl = 1'b0; post.phase = PH_STEP4; end
            PH_STEP4: begin post.sda = 1'b0; post.phase = PH_STEP5; end
            default:  fin = 1'b1;
          endcase
        end
      endcase
    end
    if (fin) begin
      post.phase    = PH_IDLE;
      post.wait_cnt = '0;
    end
    // A zero hold lets the next action run within the same tick
    cont = (post.phase != PH_IDLE) && (post.wait_cnt == '0);
  end

  assign step       = item_valid_i && !res_full_i;
  assign item_pop_o = step && !cont;
  assign res_push_o = step && !cont;

  always_comb begin
    res_o.scl  = post.scl;
    res_o.sda  = post.sda;
    res_o.oe   = post.oe;
    res_o.busy = (post.phase != PH_IDLE);
    res_o.done = done_acc_q || fin;
    res_o.rx   = post.rx;
    res_o.ack  = post.ack;
  end

  always_comb begin
    st_d       = st_q;
    mid_d      = mid_q;
    done_acc_d = done_acc_q;
    if (step) begin
      st_d = post;
      if (cont) begin
        mid_d      = 1'b1;
        done_acc_d = done_acc_q || fin;
      end else begin
        mid_d      = 1'b0;
        done_acc_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.cmd      <= OP_START;
      st_q.phase    <= PH_IDLE;
      st_q.bit_cnt  <= '0;
      st_q.shift    <= '0;
      st_q.wait_cnt <= '0;
      st_q.scl      <= 1'b0;
      st_q.sda      <= 1'b0;
      st_q.oe       <= 1'b0;
      st_q.rx       <= '0;
      st_q.ack      <= 1'b1;
      mid_q         <= 1'b0;
      done_acc_q    <= 1'b0;
    end else begin
      st_q       <= st_d;
      mid_q      <= mid_d;
      done_acc_q <= done_acc_d;
    end
  end

endmodule

### rtl/sccb_bus_master_top.sv
// Top level of the SCCB bit-level bus master.
// Each transaction pushed in is one time tick of the bus sequencer: it may
// carry a command (start, stop, write byte, read byte or NACK) for an idle
// master plus the sampled SDA level, and it yields exactly one result
// transaction with the SCL level, SDA level, SDA drive enable, busy, a done
// pulse, the last read byte and the last acknowledge bit. Commands offered
// while busy, and unknown opcodes, are ignored. A tick runs at most one bus
// action whenever the half period and the ack setup time are both non-zero;
// through zero holds it chains actions, one bus action per cycle while the
// result queue has room, and its result is pushed when the chain ends. The
// front queue holds IN_DEPTH ticks and the result queue OUT_DEPTH results,
// so a stall on one side does not stop the other until its queue fills.
// Write the configuration registers only while the master is idle and both
// queues are drained; a change takes effect at the next hold that is loaded.
module sccb_bus_master_top #(
  parameter int unsigned IN_DEPTH  = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Tick input queue
  input  logic                      push,
  output logic                      full,
  input  logic                      cmd_valid_i,
  input  logic [2:0]                op_i,
  input  logic [7:0]                tx_byte_i,
  input  logic                      sda_in_i,
  // Result queue
  output logic                      empty,
  input  logic                      pop,
  output logic                      scl_level_o,
  output logic                      sda_level_o,
  output logic                      sda_drive_o,
  output logic                      busy_res_o,
  output logic                      done_res_o,
  output logic [7:0]                rx_byte_o,
  output logic                      ack_bit_o,
  // Configuration write port
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [sbm_pkg::CFG_W-1:0] cfg_data_i
);
  import sbm_pkg::*;

  logic [CFG_W-1:0] half_period_q;
  logic [CFG_W-1:0] ack_setup_q;

  item_t item;
  logic  item_valid;
  logic  item_pop;
  res_t  res_in, res_out;
  logic  res_push;
  logic  res_full;

  // Configuration registers: plain write, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RST;
      ack_setup_q   <= ACK_SETUP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HALF_PERIOD: half_period_q <= cfg_data_i;
        CFG_ACK_SETUP:   ack_setup_q   <= cfg_data_i;
        default:         half_period_q <= half_period_q;
      endcase
    end
  end

  // Front end: classify and queue ticks
  sbm_front #(
    .DEPTH(IN_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .cmd_valid_i (cmd_valid_i),
    .op_i        (op_i),
    .tx_byte_i   (tx_byte_i),
    .sda_in_i    (sda_in_i),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_pop_i  (item_pop)
  );

  // Back end: advance the bus phases, at most one action per cycle while not stalled
  sbm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .half_period_i(half_period_q),
    .ack_setup_i  (ack_setup_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  // Hold finished results until the consumer takes them
  sbm_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign scl_level_o = res_out.scl;
  assign sda_level_o = res_out.sda;
  assign sda_drive_o = res_out.oe;
  assign busy_res_o  = res_out.busy;
  assign done_res_o  = res_out.done;
  assign rx_byte_o   = res_out.rx;
  assign ack_bit_o   = res_out.ack;

endmodule
